// ----- rtl/mlfq_pkg.sv -----
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared types and constants of the multilevel feedback queue level tracker.
// ----------------------------------------------------------------------------
package mlfq_pkg;

    // Sizes of the slot table and of the level ladder.
    localparam int SLOTS      = 16;
    localparam int LEVELS     = 5;
    localparam int NUM_QREGS  = 5;
    localparam int SLOT_W     = 4;
    localparam int SLOT_IDX_W = $clog2(SLOTS);
    localparam int LEVEL_W    = 3;
    localparam int DATA_W     = 32;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int QREG_IDX_W = $clog2(NUM_QREGS);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] QREG_LEVEL_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] QREG_LEVEL_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] QREG_LEVEL_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] QREG_LEVEL_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] QREG_LEVEL_4 = 3'd4;

    // Quantum values after reset, in microseconds.
    localparam logic [DATA_W-1:0] QUANTUM_RESET [NUM_QREGS] = '{
        32'd100000, 32'd200000, 32'd300000, 32'd400000, 32'd500000
    };

    // Event codes.
    typedef enum logic [OP_W-1:0] {
        OP_CHARGE    = 2'd0,
        OP_BOOST_ONE = 2'd1,
        OP_BOOST_ALL = 2'd2,
        OP_NONE      = 2'd3
    } op_t;

    // One request: an event for one slot.
    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [SLOT_W-1:0] slot;
        logic [DATA_W-1:0] runtime;
    } request_t;

    // One result: the state of the addressed slot after the event.
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [DATA_W-1:0]  remaining;
    } result_t;

    // Write command from the sequencer to the slot table.
    typedef struct packed {
        logic                  en;
        logic                  all;
        logic [SLOT_IDX_W-1:0] idx;
        logic [LEVEL_W-1:0]    level;
        logic [DATA_W-1:0]     remaining;
    } store_wr_t;

endpackage

// ----- rtl/mlfq_quantum_regs.sv -----
// ----------------------------------------------------------------------------
// mlfq_quantum_regs
// Quantum configuration registers with one level-indexed read port.
// ----------------------------------------------------------------------------
module mlfq_quantum_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mlfq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mlfq_pkg::DATA_W-1:0]    cfg_data,
    input  logic [mlfq_pkg::LEVEL_W-1:0]   rd_level,
    output logic [mlfq_pkg::DATA_W-1:0]    rd_quantum
);
    import mlfq_pkg::*;

    logic [DATA_W-1:0]     quantum_reg [NUM_QREGS];
    logic [QREG_IDX_W-1:0] rd_idx;

    // Writes are always taken; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QREGS; i++)
            begin
                quantum_reg[i] <= QUANTUM_RESET[i];
            end
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                QREG_LEVEL_0: quantum_reg[0] <= cfg_data;
                QREG_LEVEL_1: quantum_reg[1] <= cfg_data;
                QREG_LEVEL_2: quantum_reg[2] <= cfg_data;
                QREG_LEVEL_3: quantum_reg[3] <= cfg_data;
                QREG_LEVEL_4: quantum_reg[4] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Levels past the last register share the last quantum.
    always_comb
    begin
        if ({1'b0, rd_level} >= (LEVEL_W+1)'(NUM_QREGS))
        begin
            rd_idx = QREG_IDX_W'(NUM_QREGS - 1);
        end
        else
        begin
            rd_idx = rd_level[QREG_IDX_W-1:0];
        end
    end

    assign rd_quantum = quantum_reg[rd_idx];

endmodule

// ----- rtl/mlfq_slot_store.sv -----
// ----------------------------------------------------------------------------
// mlfq_slot_store
// Per-slot level and remaining quantum, one read and one write port.
// ----------------------------------------------------------------------------
module mlfq_slot_store (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [mlfq_pkg::SLOT_IDX_W-1:0] rd_idx,
    output logic [mlfq_pkg::LEVEL_W-1:0]    rd_level,
    output logic [mlfq_pkg::DATA_W-1:0]     rd_remaining,
    input  mlfq_pkg::store_wr_t             wr
);
    import mlfq_pkg::*;

    logic [LEVEL_W-1:0] level_reg     [SLOTS];
    logic [DATA_W-1:0]  remaining_reg [SLOTS];

    // A broadcast write touches every slot, otherwise only the addressed one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                level_reg[i]     <= '0;
                remaining_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (wr.all || (wr.idx == SLOT_IDX_W'(i)))
                begin
                    level_reg[i]     <= wr.level;
                    remaining_reg[i] <= wr.remaining;
                end
            end
        end
    end

    assign rd_level     = level_reg[rd_idx];
    assign rd_remaining = remaining_reg[rd_idx];

endmodule

// ----- rtl/mlfq_sub_unit.sv -----
// ----------------------------------------------------------------------------
// mlfq_sub_unit
// Shared 32-bit subtractor with borrow and zero flags.
// ----------------------------------------------------------------------------
module mlfq_sub_unit (
    input  logic [mlfq_pkg::DATA_W-1:0] operand_a,
    input  logic [mlfq_pkg::DATA_W-1:0] operand_b,
    output logic [mlfq_pkg::DATA_W-1:0] difference,
    output logic                        borrow,
    output logic                        is_zero
);
    import mlfq_pkg::*;

    logic [DATA_W:0] full_diff;

    // The extra top bit is the borrow out of a - b.
    assign full_diff  = {1'b0, operand_a} - {1'b0, operand_b};
    assign difference = full_diff[DATA_W-1:0];
    assign borrow     = full_diff[DATA_W];
    assign is_zero    = (full_diff[DATA_W-1:0] == '0);

endmodule

// ----- rtl/mlfq_level_tracker.sv -----
// ----------------------------------------------------------------------------
// mlfq_level_tracker
// Multilevel feedback queue tracker: per-slot level and quantum bookkeeping.
// ----------------------------------------------------------------------------
// One request is handled at a time. A boost, or an event that changes nothing,
// steps through load and done. A charge steps through load, then a compare,
// then a subtract and another compare for each level that the slot is demoted
// through, the last compare skipped when the run time ends exactly on a
// quantum boundary, and then done. Compare and subtract take turns on the
// single shared subtractor: a compare of remaining quantum against run time,
// and a subtract of the used quantum per demotion. The next request is
// accepted while a result still waits in the output register. Its own result
// then waits until that register is free, and the sequencer holds in its last
// step meanwhile, so each result stall lengthens the request.
module mlfq_level_tracker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           request_valid,
    output logic                           request_stall,
    input  mlfq_pkg::request_t             request,
    output logic                           result_valid,
    input  logic                           result_stall,
    output mlfq_pkg::result_t              result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mlfq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mlfq_pkg::DATA_W-1:0]    cfg_data
);
    import mlfq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_CMP  = 5'b00100,
        S_SUB  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    request_t           req_reg;
    logic [LEVEL_W-1:0] lvl_reg, lvl_next;
    logic [DATA_W-1:0]  rem_reg, rem_next;
    logic [DATA_W-1:0]  run_reg, run_next;
    logic               wr_pend_reg, wr_pend_next;
    result_t            result_reg;
    logic               result_valid_reg;

    logic [LEVEL_W-1:0] rd_level;
    logic [DATA_W-1:0]  rd_remaining;
    logic [LEVEL_W-1:0] rd_level_clamped;
    logic [LEVEL_W-1:0] q_level;
    logic [DATA_W-1:0]  q_value;
    logic [DATA_W-1:0]  sub_a, sub_b, sub_diff;
    logic               sub_borrow, sub_zero;
    logic               slot_ok;
    logic               at_bottom;
    logic               out_free;
    logic               accept;
    store_wr_t          store_wr;

    // Handshake decode.
    assign accept        = request_valid && !request_stall;
    assign request_stall = (state_reg != S_IDLE);
    assign out_free      = !result_valid_reg || !result_stall;
    assign result_valid  = result_valid_reg;
    assign result        = result_reg;

    assign slot_ok   = ({1'b0, req_reg.slot} < (SLOT_W+1)'(SLOTS));
    assign at_bottom = (lvl_reg >= LEVEL_W'(LEVELS - 1));

    assign rd_level_clamped = (rd_level >= LEVEL_W'(LEVELS - 1)) ?
                              LEVEL_W'(LEVELS - 1) : rd_level;

    mlfq_quantum_regs u_qregs (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .rd_level   (q_level),
        .rd_quantum (q_value)
    );

    mlfq_slot_store u_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .rd_idx       (req_reg.slot[SLOT_IDX_W-1:0]),
        .rd_level     (rd_level),
        .rd_remaining (rd_remaining),
        .wr           (store_wr)
    );

    mlfq_sub_unit u_sub (
        .operand_a  (sub_a),
        .operand_b  (sub_b),
        .difference (sub_diff),
        .borrow     (sub_borrow),
        .is_zero    (sub_zero)
    );

    // Quantum lookup level: slot level on a charge load, next level on demotion, level 0 otherwise.
    always_comb
    begin
        if (state_reg == S_SUB)
        begin
            q_level = lvl_reg + LEVEL_W'(1);
        end
        else if (req_reg.operation == OP_CHARGE)
        begin
            q_level = rd_level_clamped;
        end
        else
        begin
            q_level = '0;
        end
    end

    // The subtractor compares remaining minus run, or takes run minus quantum.
    always_comb
    begin
        if (state_reg == S_SUB)
        begin
            sub_a = run_reg;
            sub_b = rem_reg;
        end
        else
        begin
            sub_a = rem_reg;
            sub_b = run_reg;
        end
    end

    // Write back the slot when the result is handed to the output register.
    always_comb
    begin
        store_wr           = '0;
        store_wr.idx       = req_reg.slot[SLOT_IDX_W-1:0];
        store_wr.level     = lvl_reg;
        store_wr.remaining = rem_reg;
        store_wr.all       = (req_reg.operation == OP_BOOST_ALL);
        store_wr.en        = (state_reg == S_DONE) && out_free && wr_pend_reg;
    end

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        lvl_next     = lvl_reg;
        rem_next     = rem_reg;
        run_next     = run_reg;
        wr_pend_next = wr_pend_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                run_next     = req_reg.runtime;
                wr_pend_next = 1'b0;
                lvl_next     = rd_level;
                rem_next     = rd_remaining;
                state_next   = S_DONE;
                case (req_reg.operation)
                    OP_CHARGE:
                    begin
                        // A zero run time leaves the slot untouched.
                        if (slot_ok && (req_reg.runtime != '0))
                        begin
                            lvl_next     = rd_level_clamped;
                            rem_next     = (rd_remaining == '0) ? q_value : rd_remaining;
                            wr_pend_next = 1'b1;
                            state_next   = S_CMP;
                        end
                    end
                    OP_BOOST_ONE:
                    begin
                        lvl_next     = '0;
                        rem_next     = q_value;
                        wr_pend_next = slot_ok;
                    end
                    OP_BOOST_ALL:
                    begin
                        lvl_next     = '0;
                        rem_next     = q_value;
                        wr_pend_next = 1'b1;
                    end
                    default: ;
                endcase
            end
            S_CMP:
            begin
                if (!sub_borrow && !sub_zero)
                begin
                    // Run time fits inside the remaining quantum.
                    rem_next   = sub_diff;
                    state_next = S_DONE;
                end
                else if (at_bottom)
                begin
                    // The lowest level only counts down to zero.
                    rem_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SUB;
                end
            end
            S_SUB:
            begin
                // Quantum used up: demote and carry the leftover run time.
                run_next   = sub_diff;
                lvl_next   = lvl_reg + LEVEL_W'(1);
                rem_next   = q_value;
                state_next = sub_zero ? S_DONE : S_CMP;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            wr_pend_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wr_pend_reg <= wr_pend_next;
            if ((state_reg == S_DONE) && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
        lvl_reg <= lvl_next;
        rem_reg <= rem_next;
        run_reg <= run_next;
        if ((state_reg == S_DONE) && out_free)
        begin
            result_reg.level     <= slot_ok ? lvl_reg : '0;
            result_reg.remaining <= slot_ok ? rem_reg : '0;
        end
    end

    // A request is only taken while the sequencer is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_LOAD))
        else $error("accepted request did not start a load");

    // The sequencer never runs past the lowest level.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUB) |-> (lvl_reg < LEVEL_W'(LEVELS - 1)))
        else $error("demotion below the lowest level");

    // A new result only appears after the sequencer finished a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result appeared outside the done step");

    // The slot table is written only when a result is handed over.
    assert property (@(posedge clk) disable iff (!rst_n)
        store_wr.en |=> result_valid_reg)
        else $error("slot write without a result");

    // A demotion step is always followed by a compare or completion.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUB) |=> ((state_reg == S_CMP) || (state_reg == S_DONE)))
        else $error("bad step after demotion");

endmodule
